>>> hw/rtl/tba_pkg.sv
// ----------------------------------------------------------------------------
// tba_pkg: shared types and constants for the three-axis biquad accumulator
// Item layouts, coefficient set, lane step controls and register indexes.
// ----------------------------------------------------------------------------
package tba_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 32;
  localparam int COEF_BITS   = 18;
  localparam int DELAY_BITS  = 32;
  localparam int COUNT_BITS  = 16;
  localparam int NUM_AXES    = 3;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FEED_ZERO = 3'd0,
    REG_FEED_ONE  = 3'd1,
    REG_FEED_TWO  = 3'd2,
    REG_BACK_ONE  = 3'd3,
    REG_BACK_TWO  = 3'd4
  } cfg_reg_e;

  localparam logic signed [COEF_BITS-1:0] FEED_ZERO_RESET = 18'sd16384;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
    logic                          restart_sum;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_x;
    logic signed [SAMPLE_BITS-1:0] filtered_y;
    logic signed [SAMPLE_BITS-1:0] filtered_z;
    logic signed [SUM_BITS-1:0]    total_x;
    logic signed [SUM_BITS-1:0]    total_y;
    logic signed [SUM_BITS-1:0]    total_z;
    logic        [COUNT_BITS-1:0]  samples_summed;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] feed_zero;
    logic signed [COEF_BITS-1:0] feed_one;
    logic signed [COEF_BITS-1:0] feed_two;
    logic signed [COEF_BITS-1:0] back_one;
    logic signed [COEF_BITS-1:0] back_two;
  } coef_set_t;

  typedef struct packed {
    logic prod;
    logic acc;
    logic back;
    logic commit;
  } lane_step_t;

endpackage

>>> hw/rtl/tba_lane.sv
// ----------------------------------------------------------------------------
// tba_lane: one biquad section, transposed direct form II
// Feedforward products, accumulate and round, feedback products, then the
// delay state update, each step registered under its own step control.
// ----------------------------------------------------------------------------
module tba_lane
  import tba_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lane_step_t                    step_i,
  input  coef_set_t                     coef_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] filtered_o
);

  localparam int PF_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W = PF_W + 2;
  localparam int PB_W = COEF_BITS + DELAY_BITS;
  localparam int RB_W = PB_W + 1;
  localparam int D_W = RB_W + 2;

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RB_W-1:0]  RB_HALF  = RB_W'(1) << (COEF_FRAC_BITS - 1);

  localparam logic signed [ACC_W-1:0] Y_MAX =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN =
    {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] R_MAX =
    {{(ACC_W-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] R_MIN =
    {{(ACC_W-DELAY_BITS+1){1'b1}}, {(DELAY_BITS-1){1'b0}}};
  localparam logic signed [D_W-1:0] D_MAX =
    {{(D_W-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
  localparam logic signed [D_W-1:0] D_MIN =
    {{(D_W-DELAY_BITS+1){1'b1}}, {(DELAY_BITS-1){1'b0}}};

  logic signed [PF_W-1:0]        pf0_q, pf1_q, pf2_q;
  logic signed [PB_W-1:0]        pb1_q, pb2_q;
  logic signed [DELAY_BITS-1:0]  r_q;
  logic signed [SAMPLE_BITS-1:0] y_q;
  logic signed [DELAY_BITS-1:0]  d1_q, d2_q;
  logic signed [DELAY_BITS-1:0]  d1_d, d2_d;
  logic signed [DELAY_BITS-1:0]  r_d;
  logic signed [SAMPLE_BITS-1:0] y_d;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RB_W-1:0]  rb1, rb2;
  logic signed [D_W-1:0]   d1_sum, d2_sum;

  always_comb begin
    acc = ACC_W'(pf0_q) + ACC_W'(d1_q);
    acc_rnd = (acc + ACC_HALF) >>> COEF_FRAC_BITS;

    if (acc > R_MAX) begin
      r_d = R_MAX[DELAY_BITS-1:0];
    end else if (acc < R_MIN) begin
      r_d = R_MIN[DELAY_BITS-1:0];
    end else begin
      r_d = acc[DELAY_BITS-1:0];
    end

    if (acc_rnd > Y_MAX) begin
      y_d = Y_MAX[SAMPLE_BITS-1:0];
    end else if (acc_rnd < Y_MIN) begin
      y_d = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_d = acc_rnd[SAMPLE_BITS-1:0];
    end

    rb1 = (RB_W'(pb1_q) + RB_HALF) >>> COEF_FRAC_BITS;
    rb2 = (RB_W'(pb2_q) + RB_HALF) >>> COEF_FRAC_BITS;
    d1_sum = D_W'(pf1_q) - D_W'(rb1) + D_W'(d2_q);
    d2_sum = D_W'(pf2_q) - D_W'(rb2);

    if (d1_sum > D_MAX) begin
      d1_d = D_MAX[DELAY_BITS-1:0];
    end else if (d1_sum < D_MIN) begin
      d1_d = D_MIN[DELAY_BITS-1:0];
    end else begin
      d1_d = d1_sum[DELAY_BITS-1:0];
    end

    if (d2_sum > D_MAX) begin
      d2_d = D_MAX[DELAY_BITS-1:0];
    end else if (d2_sum < D_MIN) begin
      d2_d = D_MIN[DELAY_BITS-1:0];
    end else begin
      d2_d = d2_sum[DELAY_BITS-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (step_i.prod) begin
      pf0_q <= PF_W'(coef_i.feed_zero) * PF_W'(sample_i);
      pf1_q <= PF_W'(coef_i.feed_one) * PF_W'(sample_i);
      pf2_q <= PF_W'(coef_i.feed_two) * PF_W'(sample_i);
    end
    if (step_i.acc) begin
      r_q <= r_d;
      y_q <= y_d;
    end
    if (step_i.back) begin
      pb1_q <= PB_W'(coef_i.back_one) * PB_W'(r_q);
      pb2_q <= PB_W'(coef_i.back_two) * PB_W'(r_q);
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (step_i.commit) begin
      d1_q <= d1_d;
      d2_q <= d2_d;
    end
  end

  assign filtered_o = y_q;

endmodule

>>> hw/rtl/tba_merge.sv
// ----------------------------------------------------------------------------
// tba_merge: running totals, sample count and output register
// Combines the lane outputs into one result item and holds it until taken.
// ----------------------------------------------------------------------------
module tba_merge
  import tba_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          commit_i,
  input  logic                          restart_i,
  input  logic signed [SAMPLE_BITS-1:0] filtered_i [NUM_AXES],
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output out_item_t                     out_item_o
);

  localparam int T_W = SUM_BITS + 1;
  localparam logic signed [T_W-1:0] T_MAX = {2'b00, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_MIN = {2'b11, {(SUM_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic signed [SUM_BITS-1:0] total_q [NUM_AXES];
  logic signed [SUM_BITS-1:0] total_d [NUM_AXES];
  logic [COUNT_BITS-1:0]      count_q, count_d, count_base;
  logic                       out_valid_q;
  out_item_t                  out_item_q, out_item_d;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic signed [SUM_BITS-1:0] base;
      logic signed [T_W-1:0]      sum;
      base = restart_i ? '0 : total_q[a];
      sum = T_W'(base) + T_W'(filtered_i[a]);
      if (sum > T_MAX) begin
        total_d[a] = T_MAX[SUM_BITS-1:0];
      end else if (sum < T_MIN) begin
        total_d[a] = T_MIN[SUM_BITS-1:0];
      end else begin
        total_d[a] = sum[SUM_BITS-1:0];
      end
    end

    count_base = restart_i ? '0 : count_q;
    count_d = (count_base == COUNT_MAX) ? count_base : count_base + COUNT_BITS'(1);

    out_item_d.filtered_x     = filtered_i[0];
    out_item_d.filtered_y     = filtered_i[1];
    out_item_d.filtered_z     = filtered_i[2];
    out_item_d.total_x        = total_d[0];
    out_item_d.total_y        = total_d[1];
    out_item_d.total_z        = total_d[2];
    out_item_d.samples_summed = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        total_q[a] <= '0;
      end
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit_i) begin
        total_q     <= total_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> hw/rtl/three_axis_biquad_accumulate.sv
// ----------------------------------------------------------------------------
// three_axis_biquad_accumulate: three-axis biquad filter with running sums
// The input stalls while an item is in flight, so a new item is accepted only
// after the per-item step sequence of feedforward multiply, accumulate,
// feedback multiply and state update has committed its result.
// A result still waiting at the update step holds it, and the input stalls.
// Reset clears filter state, totals and count; coefficients return to b0 = 1.0.
// ----------------------------------------------------------------------------
module three_axis_biquad_accumulate
  import tba_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_item_t               out_item_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [COEF_BITS-1:0]    cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_BACK,
    ST_DONE
  } state_e;

  state_e                        state_q;
  logic                          restart_q;
  coef_set_t                     coef_q;
  lane_step_t                    step;
  logic                          accept;
  logic signed [SAMPLE_BITS-1:0] sample [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] filtered [NUM_AXES];

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign step.prod   = accept;
  assign step.acc    = (state_q == ST_ACC);
  assign step.back   = (state_q == ST_BACK);
  assign step.commit = (state_q == ST_DONE) && (!out_valid_o || !out_stall_i);

  assign sample[0] = in_item_i.sample_x;
  assign sample[1] = in_item_i.sample_y;
  assign sample[2] = in_item_i.sample_z;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.feed_zero <= FEED_ZERO_RESET;
      coef_q.feed_one  <= '0;
      coef_q.feed_two  <= '0;
      coef_q.back_one  <= '0;
      coef_q.back_two  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FEED_ZERO: coef_q.feed_zero <= cfg_data_i;
        REG_FEED_ONE:  coef_q.feed_one  <= cfg_data_i;
        REG_FEED_TWO:  coef_q.feed_two  <= cfg_data_i;
        REG_BACK_ONE:  coef_q.back_one  <= cfg_data_i;
        REG_BACK_TWO:  coef_q.back_two  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      restart_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            restart_q <= in_item_i.restart_sum;
            state_q   <= ST_ACC;
          end
        end
        ST_ACC:  state_q <= ST_BACK;
        ST_BACK: state_q <= ST_DONE;
        ST_DONE: begin
          if (step.commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    tba_lane #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (step),
      .coef_i     (coef_q),
      .sample_i   (sample[a]),
      .filtered_o (filtered[a])
    );
  end

  tba_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .commit_i    (step.commit),
    .restart_i   (restart_q),
    .filtered_i  (filtered),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
